[design/pid_deadzone_clamped_macros.svh]
// Assertion macros shared by the PID controller modules
`ifndef PID_DEADZONE_CLAMPED_MACROS_SVH
`define PID_DEADZONE_CLAMPED_MACROS_SVH

// Same-cycle implication
`define PDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define PDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pdc_pkg.sv]
// Types and constants of the PID controller
package pdc_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned CFG_W     = 31;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned DERIV_W   = DATA_W + 1;
   localparam int unsigned PROD_W    = 64;
   localparam int unsigned SUM_W     = PROD_W + 2;
   localparam int unsigned RES_W     = SUM_W - FRAC_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_PROPORTIONAL = 3'd0,
      CSR_GAIN_INTEGRAL     = 3'd1,
      CSR_GAIN_DERIVATIVE   = 3'd2,
      CSR_DEAD_ZONE         = 3'd3,
      CSR_INTEGRATE_WINDOW  = 3'd4,
      CSR_INTEGRAL_LIMIT    = 3'd5,
      CSR_OUTPUT_LIMIT      = 3'd6
   } csr_index_type;

   typedef logic [CFG_W-1:0] cfg_word_type;

   typedef struct packed {
      cfg_word_type gain_proportional;
      cfg_word_type gain_integral;
      cfg_word_type gain_derivative;
      cfg_word_type dead_zone;
      cfg_word_type integrate_window;
      cfg_word_type integral_limit;
      cfg_word_type output_limit;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0]  error;
      logic [DATA_W-1:0]  integral;
      logic [DERIV_W-1:0] deriv;
   } pid_terms_type;

   typedef struct packed {
      logic [PROD_W-1:0] p_prod;
      logic [PROD_W-1:0] i_prod;
      logic [PROD_W-1:0] d_prod;
   } pid_prods_type;

endpackage

[design/pdc_if.sv]
// Request and response channel interfaces of the PID controller
interface pdc_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [pdc_pkg::DATA_W-1:0] measured_value;
   logic signed [pdc_pkg::DATA_W-1:0] setpoint;

   modport source (output valid, output measured_value, output setpoint, input ready);
   modport sink   (input valid, input measured_value, input setpoint, output ready);
endinterface

interface pdc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pdc_pkg::DATA_W-1:0] drive_output;
   logic                              output_saturated;

   modport source (output valid, output drive_output, output output_saturated, input ready);
   modport sink   (input valid, input drive_output, input output_saturated, output ready);
endinterface

[design/pdc_csr.sv]
// Configuration register file of the PID controller
module pdc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [pdc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pdc_pkg::CFG_W-1:0]       csr_wdata,
   output pdc_pkg::cfg_type                cfg
);

   pdc_pkg::cfg_type cfg_ff;
   pdc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (pdc_pkg::csr_index_type'(csr_index))
            pdc_pkg::CSR_GAIN_PROPORTIONAL: cfg_in.gain_proportional = csr_wdata;
            pdc_pkg::CSR_GAIN_INTEGRAL:     cfg_in.gain_integral     = csr_wdata;
            pdc_pkg::CSR_GAIN_DERIVATIVE:   cfg_in.gain_derivative   = csr_wdata;
            pdc_pkg::CSR_DEAD_ZONE:         cfg_in.dead_zone         = csr_wdata;
            pdc_pkg::CSR_INTEGRATE_WINDOW:  cfg_in.integrate_window  = csr_wdata;
            pdc_pkg::CSR_INTEGRAL_LIMIT:    cfg_in.integral_limit    = csr_wdata;
            pdc_pkg::CSR_OUTPUT_LIMIT:      cfg_in.output_limit      = csr_wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/pdc_error_stage.sv]
// Input register, error saturation, dead zone and integral recurrence
`include "pid_deadzone_clamped_macros.svh"

module pdc_error_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  pdc_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [pdc_pkg::DATA_W-1:0] measured_value,
   input  logic signed [pdc_pkg::DATA_W-1:0] setpoint,
   output logic                              out_valid,
   input  logic                              out_ready,
   output pdc_pkg::pid_terms_type            terms
);

   localparam int unsigned W  = pdc_pkg::DATA_W;
   localparam int unsigned DW = pdc_pkg::DERIV_W;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic signed [W-1:0]    meas_ff;
   logic signed [W-1:0]    sp_ff;
   logic                   terms_valid_ff;
   logic                   terms_valid_in;
   pdc_pkg::pid_terms_type terms_ff;
   pdc_pkg::pid_terms_type terms_in;
   logic signed [W-1:0]    integral_ff;
   logic signed [W-1:0]    integral_in;
   logic signed [W-1:0]    last_error_ff;
   logic signed [W-1:0]    last_error_in;

   logic                   adv_out;
   logic                   adv_in;
   logic                   xfer;
   logic signed [W:0]      diff;
   logic signed [W-1:0]    err_sat;
   logic [W-1:0]           err_mag;
   logic                   dz_hit;
   logic                   integrate;
   logic signed [W-1:0]    err_eff;
   logic signed [W-1:0]    integ_base;
   logic signed [W-1:0]    last_base;
   logic signed [W:0]      integ_sum;
   logic signed [W:0]      lim_pos;
   logic signed [W:0]      lim_neg;
   logic signed [W:0]      integ_clamp;
   logic signed [DW-1:0]   deriv;

   assign adv_out  = !terms_valid_ff || out_ready;
   assign adv_in   = !in_valid_ff || adv_out;
   assign xfer     = in_valid_ff && adv_out;
   assign in_ready = adv_in;

   assign in_valid_in    = adv_in ? in_valid : in_valid_ff;
   assign terms_valid_in = adv_out ? in_valid_ff : terms_valid_ff;

   always_comb begin
      diff = {sp_ff[W-1], sp_ff} - {meas_ff[W-1], meas_ff};
      if (diff[W] != diff[W-1]) begin
         err_sat = diff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         err_sat = diff[W-1:0];
      end
      err_mag = err_sat[W-1] ? (~err_sat + 1'b1) : err_sat;
      dz_hit  = err_mag <= {1'b0, cfg.dead_zone};

      err_eff    = dz_hit ? '0 : err_sat;
      integ_base = dz_hit ? '0 : integral_ff;
      last_base  = dz_hit ? '0 : last_error_ff;
      integrate  = dz_hit || (err_mag <= {1'b0, cfg.integrate_window});

      integ_sum = {integ_base[W-1], integ_base} + {err_eff[W-1], err_eff};
      lim_pos   = {2'b00, cfg.integral_limit};
      lim_neg   = -lim_pos;
      if (integ_sum > lim_pos) begin
         integ_clamp = lim_pos;
      end else if (integ_sum < lim_neg) begin
         integ_clamp = lim_neg;
      end else begin
         integ_clamp = integ_sum;
      end
      integral_in   = integrate ? integ_clamp[W-1:0] : integ_base;
      last_error_in = err_eff;

      deriv = {err_eff[W-1], err_eff} - {last_base[W-1], last_base};

      terms_in.error    = err_eff;
      terms_in.integral = integral_in;
      terms_in.deriv    = deriv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         terms_valid_ff <= 1'b0;
         integral_ff    <= '0;
         last_error_ff  <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         terms_valid_ff <= terms_valid_in;
         if (xfer) begin
            integral_ff   <= integral_in;
            last_error_ff <= last_error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && adv_in) begin
         meas_ff <= measured_value;
         sp_ff   <= setpoint;
      end
      if (xfer) begin
         terms_ff <= terms_in;
      end
   end

   assign out_valid = terms_valid_ff;
   assign terms     = terms_ff;

   `PDC_ASSERT_NEXT(a_last_error_tracks, clock, reset, xfer,
      last_error_ff == terms_ff.error, "previous error differs from forwarded error")
   `PDC_ASSERT_NEXT(a_integral_tracks, clock, reset, xfer,
      integral_ff == terms_ff.integral, "integral state differs from forwarded integral")
   `PDC_ASSERT_SAME(a_reset_clears_state, clock, 1'b0, $past(reset),
      (integral_ff == '0) && (last_error_ff == '0), "controller history not cleared by reset")

endmodule

[design/pdc_product_stage.sv]
// Gain multipliers of the PID controller
module pdc_product_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  pdc_pkg::cfg_type       cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pdc_pkg::pid_terms_type terms,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pdc_pkg::pid_prods_type prods
);

   localparam int unsigned W  = pdc_pkg::DATA_W;
   localparam int unsigned DW = pdc_pkg::DERIV_W;
   localparam int unsigned PW = pdc_pkg::PROD_W;

   logic                   valid_ff;
   logic                   valid_in;
   pdc_pkg::pid_prods_type prods_ff;
   pdc_pkg::pid_prods_type prods_in;
   logic                   load;
   logic signed [W-1:0]    kp;
   logic signed [W-1:0]    ki;
   logic signed [W-1:0]    kd;
   logic signed [W-1:0]    err;
   logic signed [W-1:0]    integ;
   logic signed [DW-1:0]   deriv;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      kp    = {1'b0, cfg.gain_proportional};
      ki    = {1'b0, cfg.gain_integral};
      kd    = {1'b0, cfg.gain_derivative};
      err   = terms.error;
      integ = terms.integral;
      deriv = terms.deriv;
      prods_in.p_prod = PW'(kp * err);
      prods_in.i_prod = PW'(ki * integ);
      prods_in.d_prod = PW'(kd * deriv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prods_ff <= prods_in;
      end
   end

   assign out_valid = valid_ff;
   assign prods     = prods_ff;

endmodule

[design/pdc_output_stage.sv]
// Product sum, scaling, output clamp and result register
`include "pid_deadzone_clamped_macros.svh"

module pdc_output_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  pdc_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  pdc_pkg::pid_prods_type            prods,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [pdc_pkg::DATA_W-1:0] drive_output,
   output logic                              output_saturated
);

   localparam int unsigned W  = pdc_pkg::DATA_W;
   localparam int unsigned SW = pdc_pkg::SUM_W;
   localparam int unsigned RW = pdc_pkg::RES_W;
   localparam int unsigned FW = pdc_pkg::FRAC_W;

   logic                 valid_ff;
   logic                 valid_in;
   logic signed [W-1:0]  drive_ff;
   logic signed [W-1:0]  drive_in;
   logic                 sat_ff;
   logic                 sat_in;
   logic                 load;
   logic signed [SW-1:0] sum;
   logic signed [RW-1:0] scaled;
   logic signed [RW-1:0] olim_pos;
   logic signed [RW-1:0] olim_neg;
   logic signed [W-1:0]  olim_w;
   logic signed [W-1:0]  olim_neg_w;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      sum = SW'($signed(prods.p_prod)) + SW'($signed(prods.i_prod))
          + SW'($signed(prods.d_prod));
      scaled     = sum[SW-1:FW];
      olim_pos   = RW'({1'b0, cfg.output_limit});
      olim_neg   = -olim_pos;
      olim_w     = {1'b0, cfg.output_limit};
      olim_neg_w = -olim_w;
      if (scaled > olim_pos) begin
         drive_in = olim_w;
         sat_in   = 1'b1;
      end else if (scaled < olim_neg) begin
         drive_in = olim_neg_w;
         sat_in   = 1'b1;
      end else begin
         drive_in = scaled[W-1:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff <= drive_in;
         sat_ff   <= sat_in;
      end
   end

   assign out_valid        = valid_ff;
   assign drive_output     = drive_ff;
   assign output_saturated = sat_ff;

   `PDC_ASSERT_NEXT(a_sat_at_limit, clock, reset, load,
      !sat_ff || (drive_ff == $past(olim_w)) || (drive_ff == $past(olim_neg_w)),
      "saturated output not at the limit")
   `PDC_ASSERT_NEXT(a_drive_in_range, clock, reset, load,
      (drive_ff <= $past(olim_w)) && (drive_ff >= $past(olim_neg_w)),
      "drive output beyond the output limit")

endmodule

[design/pid_deadzone_clamped.sv]
// Top level of the PID controller with dead zone and clamps
//
// Usage: each request on req_if carries one control sample (measured_value,
// setpoint, signed Q16.16) and yields exactly one response on rsp_if
// (drive_output, signed Q16.16, and output_saturated). Both channels use a
// valid/ready handshake; a transfer happens on a rising clock edge with both
// high. Gains, dead zone, integration window and limits are written through
// csr_wr_en/csr_index/csr_wdata while no request is in flight; writes to an
// unknown index are dropped. A request passes the input, terms, product and
// result registers before its response is presented. Throughput: one
// request per cycle unless rsp_if stalls; the integral and previous-error
// update is done in the single error stage, so samples follow back to back.
// Reset (synchronous, active high) clears the configuration registers, the
// integral and the previous error, and empties the pipeline.
// When the receiver stalls, each stage holds its item and fills in turn; the
// input keeps taking requests until every stage is occupied.
module pid_deadzone_clamped (
   input  logic                          clock,
   input  logic                          reset,
   pdc_req_if.sink                       req_if,
   pdc_rsp_if.source                     rsp_if,
   input  logic                          csr_wr_en,
   input  logic [pdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdc_pkg::CFG_W-1:0]     csr_wdata
);

   pdc_pkg::cfg_type       cfg;
   pdc_pkg::pid_terms_type terms;
   pdc_pkg::pid_prods_type prods;
   logic                   terms_valid;
   logic                   terms_ready;
   logic                   prods_valid;
   logic                   prods_ready;

   pdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pdc_error_stage u_error (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .in_valid       (req_if.valid),
      .in_ready       (req_if.ready),
      .measured_value (req_if.measured_value),
      .setpoint       (req_if.setpoint),
      .out_valid      (terms_valid),
      .out_ready      (terms_ready),
      .terms          (terms)
   );

   pdc_product_stage u_product (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (terms_valid),
      .in_ready  (terms_ready),
      .terms     (terms),
      .out_valid (prods_valid),
      .out_ready (prods_ready),
      .prods     (prods)
   );

   pdc_output_stage u_output (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .in_valid         (prods_valid),
      .in_ready         (prods_ready),
      .prods            (prods),
      .out_valid        (rsp_if.valid),
      .out_ready        (rsp_if.ready),
      .drive_output     (rsp_if.drive_output),
      .output_saturated (rsp_if.output_saturated)
   );

endmodule
